[rtl/saq_pkg.sv]
package saq_pkg;

	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int HANDLER_W = 8;
	localparam int SLOT_W = 4;
	localparam int PURGE_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIRE   = 2'd2,
		CMD_SETTM  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOUSE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

endpackage

[rtl/saq_if.sv]
interface saq_if #(
	parameter int W = 8
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/saq_front.sv]
// Front end: takes requests and queues them for the back end.
module saq_front
	import saq_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         q_valid,
	input  logic         q_ready,
	output logic [W-1:0] q_data
);
	// two-entry queue
	logic [W-1:0] buf_q [2];
	logic         rd_q, wr_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_data;
	end
endmodule

[rtl/saq_back.sv]
// Back end: sequencer working the slot pool one order position per cycle.
module saq_back
	import saq_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 32,
	parameter int DATA_BITS = 32,
	parameter int IW = 8,
	parameter int OW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [IW-1:0] q_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [OW-1:0] out_data
);
	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHIFT, S_RUN, S_FIRE, S_EMIT, S_DONE
	} state_t;

	// decoded request fields
	logic [CMD_W-1:0]     r_cmd;
	logic [TIME_BITS-1:0] r_time;
	logic [HANDLER_W-1:0] r_hand;
	logic [DATA_BITS-1:0] r_data;
	logic [SLOT_W-1:0]    r_slot;
	assign {r_cmd, r_time, r_hand, r_data, r_slot} = q_data;

	logic [TIME_BITS-1:0] time_q [SLOTS];
	logic [HANDLER_W-1:0] hand_q [SLOTS];
	logic [DATA_BITS-1:0] data_q [SLOTS];
	logic [SW-1:0]        ord_q  [SLOTS];
	logic [SLOTS-1:0]     used_q;
	logic [CW-1:0]        cnt_q;

	state_t               st_q;
	cmd_t                 cmd_q;
	logic [TIME_BITS-1:0] t_q;
	logic [SW-1:0]        slot_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        pos_q;
	logic [CW-1:0]        n_q;
	logic [TIME_BITS-1:0] head_q;

	logic                 ov_q;
	logic [STATUS_W-1:0]  o_st_q;
	logic [SLOT_W-1:0]    o_slot_q;
	logic [HANDLER_W-1:0] o_hand_q;
	logic [DATA_BITS-1:0] o_data_q;
	logic [PURGE_W-1:0]   o_pur_q;
	logic [31:0]          o_next_q;
	logic                 o_ne_q;
	logic                 o_last_q;

	// lowest free slot
	logic [SW-1:0] free_s;
	logic          free_ok;
	always_comb begin
		free_s  = '0;
		free_ok = 1'b0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_s  = SW'(k);
				free_ok = 1'b1;
			end
		end
	end

	logic [SW-1:0]        cur_slot;
	logic [TIME_BITS-1:0] cur_time;
	assign cur_slot = ord_q[i_q[SW-1:0]];
	assign cur_time = time_q[cur_slot];

	logic [TIME_BITS-1:0] head_time;
	logic                 nonempty;
	assign nonempty  = (cnt_q != '0);
	assign head_time = nonempty ? time_q[ord_q[0]] : '0;

	// a new request waits until the previous response has gone
	assign q_ready   = (st_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign out_data  = {o_st_q, o_slot_q, o_hand_q, 32'(o_data_q), o_pur_q,
		o_next_q, o_ne_q, o_last_q};

	logic rsl_free;
	assign rsl_free = !ov_q || out_ready;

	// response register loads at the end of a command or of each fired alarm
	logic rsp_set;
	always_comb begin
		rsp_set = 1'b0;
		if (st_q == S_DONE && rsl_free) rsp_set = 1'b1;
		if (st_q == S_EMIT && !(pos_q + 1'b1 < cnt_q)) rsp_set = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			used_q <= '0;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (rsp_set) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_valid && !ov_q) begin
					cmd_q    <= cmd_t'(r_cmd);
					t_q      <= r_time;
					i_q      <= '0;
					n_q      <= '0;
					o_hand_q <= '0;
					o_data_q <= '0;
					o_pur_q  <= '0;
					o_last_q <= 1'b1;
					unique case (cmd_t'(r_cmd))
						CMD_INSERT: begin
							if (!free_ok) begin
								o_st_q   <= ST_FULL;
								o_slot_q <= '0;
								st_q     <= S_DONE;
							end else begin
								time_q[free_s] <= r_time;
								hand_q[free_s] <= r_hand;
								data_q[free_s] <= r_data;
								used_q[free_s] <= 1'b1;
								slot_q   <= free_s;
								o_st_q   <= ST_OK;
								o_slot_q <= SLOT_W'(free_s);
								pos_q    <= cnt_q;
								st_q     <= S_SCAN;
							end
						end
						CMD_REMOVE: begin
							o_slot_q <= '0;
							slot_q   <= SW'(r_slot);
							if (32'(r_slot) >= SLOTS || !used_q[SW'(r_slot)]) begin
								o_st_q <= ST_NOUSE;
								st_q   <= S_DONE;
							end else begin
								used_q[SW'(r_slot)] <= 1'b0;
								o_st_q <= ST_OK;
								pos_q  <= cnt_q;
								st_q   <= S_SCAN;
							end
						end
						CMD_FIRE: begin
							o_slot_q <= '0;
							if (!nonempty) begin
								o_st_q <= ST_EMPTY;
								st_q   <= S_DONE;
							end else begin
								o_st_q <= ST_OK;
								head_q <= head_time;
								st_q   <= S_RUN;
							end
						end
						default: begin
							o_st_q   <= ST_OK;
							o_slot_q <= '0;
							pos_q    <= '0;
							st_q     <= S_SCAN;
						end
					endcase
				end
				// one order position per cycle
				S_SCAN: begin
					if (i_q >= cnt_q) begin
						if (cmd_q == CMD_SETTM) begin
							n_q  <= i_q;
							pos_q <= '0;
							o_pur_q <= PURGE_W'(i_q);
							st_q <= (i_q == '0) ? S_DONE : S_SHIFT;
							i_q  <= '0;
						end else if (cmd_q == CMD_REMOVE) begin
							st_q <= S_DONE;
						end else begin
							i_q  <= cnt_q;
							st_q <= S_SHIFT;
						end
					end else begin
						unique case (cmd_q)
							CMD_INSERT: begin
								if (cur_time >= t_q) begin
									pos_q <= (cur_time == t_q) ? i_q + 1'b1 : i_q;
									i_q   <= cnt_q;
									st_q  <= S_SHIFT;
								end else i_q <= i_q + 1'b1;
							end
							CMD_REMOVE: begin
								if (cur_slot == slot_q) begin
									pos_q <= i_q;
									n_q   <= CW'(1);
									st_q  <= S_SHIFT;
								end else i_q <= i_q + 1'b1;
							end
							default: begin
								if (cur_time <= t_q) i_q <= i_q + 1'b1;
								else begin
									n_q  <= i_q;
									o_pur_q <= PURGE_W'(i_q);
									st_q <= (i_q == '0) ? S_DONE : S_SHIFT;
									i_q  <= '0;
								end
							end
						endcase
					end
				end
				// order list shifts, one entry per cycle
				S_SHIFT: begin
					if (cmd_q == CMD_INSERT) begin
						if (i_q > pos_q) begin
							ord_q[i_q[SW-1:0]] <= ord_q[i_q[SW-1:0] - 1'b1];
							i_q <= i_q - 1'b1;
						end else begin
							ord_q[pos_q[SW-1:0]] <= slot_q;
							cnt_q <= cnt_q + 1'b1;
							st_q  <= S_DONE;
						end
					end else begin
						// drop n_q entries starting at pos_q
						if (i_q < n_q) begin
							used_q[ord_q[i_q[SW-1:0]]] <= (cmd_q == CMD_REMOVE)
								? used_q[ord_q[i_q[SW-1:0]]] : 1'b0;
							i_q <= i_q + 1'b1;
						end else if (pos_q + n_q < cnt_q) begin
							ord_q[pos_q[SW-1:0]] <= ord_q[SW'(pos_q + n_q)];
							pos_q <= pos_q + 1'b1;
						end else begin
							cnt_q <= cnt_q - n_q;
							st_q  <= S_DONE;
						end
					end
				end
				// measure the head run and the head left behind once it is gone
				S_RUN: begin
					if (i_q < cnt_q && cur_time == head_q) i_q <= i_q + 1'b1;
					else begin
						n_q      <= i_q;
						o_next_q <= (i_q < cnt_q) ? 32'(cur_time) : 32'd0;
						o_ne_q   <= (i_q < cnt_q);
						st_q     <= S_FIRE;
					end
				end
				// head run with equal time: emit then free, one per pass
				S_FIRE: begin
					if (!ov_q) begin
						o_st_q <= ST_OK;
						o_slot_q <= SLOT_W'(ord_q[0]);
						o_hand_q <= hand_q[ord_q[0]];
						o_data_q <= data_q[ord_q[0]];
						used_q[ord_q[0]] <= 1'b0;
						o_last_q <= (n_q == CW'(1));
						n_q   <= n_q - 1'b1;
						pos_q <= '0;
						st_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (pos_q + 1'b1 < cnt_q) begin
						ord_q[pos_q[SW-1:0]] <= ord_q[SW'(pos_q + 1'b1)];
						pos_q <= pos_q + 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						st_q  <= o_last_q ? S_IDLE : S_FIRE;
					end
				end
				S_DONE: begin
					if (rsl_free) begin
						o_next_q <= 32'(head_time);
						o_ne_q   <= nonempty;
						st_q     <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/sorted_alarm_queue_top.sv]
// channel | direction | payload
// req     | in        | cmd, time_value, handler, callback_data, slot_id
// rsp     | out       | status, out_slot, fired_handler, fired_data, purged_count,
//         |           | next_alarm, queue_nonempty, last
// A request is taken, then one order position a cycle: insert and remove scan
// the order list, then shift it; set time scans, frees the purged slots and shifts.
// A fire scans the head run, then emits, frees and shifts out each alarm in turn.
// The next request is taken only once the last response has gone.
// arst_n clears slot occupancy and counts; slot contents need no reset.
// A stalled response holds the sequencer; a two-deep queue still takes requests.
module sorted_alarm_queue_top
	import saq_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int TIME_BITS = 32,
	parameter int DATA_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	saq_if.sink   req,
	saq_if.source rsp
);
	localparam int IW = CMD_W + TIME_BITS + HANDLER_W + DATA_BITS + SLOT_W;
	localparam int OW = STATUS_W + SLOT_W + HANDLER_W + 32 + PURGE_W + 32 + 2;

	// request field positions on the channel
	localparam int RQ_SLOT = 0;
	localparam int RQ_DATA = RQ_SLOT + SLOT_W;
	localparam int RQ_HAND = RQ_DATA + 32;
	localparam int RQ_TIME = RQ_HAND + HANDLER_W;
	localparam int RQ_CMD  = RQ_TIME + 32;

	logic          qv, qr;
	logic [IW-1:0] qd;
	logic [IW-1:0] in_d;
	assign in_d = {req.data[RQ_CMD +: CMD_W], TIME_BITS'(req.data[RQ_TIME +: 32]),
		req.data[RQ_HAND +: HANDLER_W], DATA_BITS'(req.data[RQ_DATA +: 32]),
		req.data[RQ_SLOT +: SLOT_W]};

	saq_front #(.W(IW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(in_d),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	logic [OW-1:0] od;
	saq_back #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .DATA_BITS(DATA_BITS),
		.IW(IW), .OW(OW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(od)
	);

	assign rsp.data = od;
endmodule

[dv/sorted_alarm_queue_top_tb.sv]
`timescale 1ns / 1ps

module sorted_alarm_queue_top_tb;
	import saq_pkg::*;

	localparam int NSLOT = 16;
	localparam int REQ_W = CMD_W + 32 + HANDLER_W + 32 + SLOT_W;
	localparam int RSP_W = STATUS_W + SLOT_W + HANDLER_W + 32 + PURGE_W + 32 + 1 + 1;
	localparam int STALL_LIMIT = 20000;
	localparam int N_RANDOM = 450;

	typedef struct packed {
		cmd_t                 cmd;
		logic [31:0]          time_value;
		logic [HANDLER_W-1:0] handler;
		logic [31:0]          callback_data;
		logic [SLOT_W-1:0]    slot_id;
	} alarm_req_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_W-1:0]    out_slot;
		logic [HANDLER_W-1:0] fired_handler;
		logic [31:0]          fired_data;
		logic [PURGE_W-1:0]   purged_count;
		logic [31:0]          next_alarm;
		logic                 queue_nonempty;
		logic                 last;
	} alarm_rsp_t;

	// directed row: request plus an optional hand-written status
	typedef struct {
		alarm_req_t req;
		bit         chk;
		status_t    st;
	} dir_row_t;

	logic clk;
	logic arst_n;

	saq_if #(.W(REQ_W)) req_if ();
	saq_if #(.W(RSP_W)) rsp_if ();

	sorted_alarm_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// shadow copy of the alarm pool
	logic [31:0]          slot_time [NSLOT];
	logic [HANDLER_W-1:0] slot_handler [NSLOT];
	logic [31:0]          slot_data [NSLOT];
	bit                   slot_busy [NSLOT];
	logic [SLOT_W-1:0]    alarm_order [$];

	alarm_rsp_t pending_rsp [$];
	dir_row_t   dir_rows [$];
	int         err_cnt;
	int         src_idle;
	int         snk_idle;
	int         quiet_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic alarm_rsp_t mk_rsp(status_t st, logic [SLOT_W-1:0] sl,
			logic [HANDLER_W-1:0] h, logic [31:0] d, logic [PURGE_W-1:0] p, bit lst);
		alarm_rsp_t r;
		r.status         = st;
		r.out_slot       = sl;
		r.fired_handler  = h;
		r.fired_data     = d;
		r.purged_count   = p;
		r.next_alarm     = alarm_order.size() ? slot_time[alarm_order[0]] : 32'd0;
		r.queue_nonempty = alarm_order.size() != 0;
		r.last           = lst;
		return r;
	endfunction

	// apply one request to the shadow pool and queue what the block should answer
	function automatic status_t predict_alarm(alarm_req_t q);
		int s;
		int pos;
		int n;
		logic [31:0] head;
		logic [SLOT_W-1:0] fired [$];
		alarm_rsp_t r;
		s = -1;
		case (q.cmd)
			CMD_INSERT: begin
				for (int i = NSLOT - 1; i >= 0; i--)
					if (!slot_busy[i]) s = i;
				if (s < 0) begin
					r = mk_rsp(ST_FULL, 0, 0, 0, 0, 1);
				end else begin
					slot_time[s] = q.time_value;
					slot_handler[s] = q.handler;
					slot_data[s] = q.callback_data;
					slot_busy[s] = 1;
					pos = alarm_order.size();
					for (int i = 0; i < alarm_order.size(); i++) begin
						if (slot_time[alarm_order[i]] >= q.time_value) begin
							pos = (slot_time[alarm_order[i]] == q.time_value) ? i + 1 : i;
							break;
						end
					end
					alarm_order.insert(pos, s[SLOT_W-1:0]);
					r = mk_rsp(ST_OK, s[SLOT_W-1:0], 0, 0, 0, 1);
				end
				pending_rsp.push_back(r);
			end
			CMD_REMOVE: begin
				if (!slot_busy[q.slot_id]) begin
					r = mk_rsp(ST_NOUSE, 0, 0, 0, 0, 1);
				end else begin
					for (int i = 0; i < alarm_order.size(); i++) begin
						if (alarm_order[i] == q.slot_id) begin
							alarm_order.delete(i);
							break;
						end
					end
					slot_busy[q.slot_id] = 0;
					r = mk_rsp(ST_OK, 0, 0, 0, 0, 1);
				end
				pending_rsp.push_back(r);
			end
			CMD_FIRE: begin
				if (alarm_order.size() == 0) begin
					pending_rsp.push_back(mk_rsp(ST_EMPTY, 0, 0, 0, 0, 1));
				end else begin
					head = slot_time[alarm_order[0]];
					while (alarm_order.size() && slot_time[alarm_order[0]] == head) begin
						fired.push_back(alarm_order[0]);
						slot_busy[alarm_order[0]] = 0;
						void'(alarm_order.pop_front());
					end
					foreach (fired[i])
						pending_rsp.push_back(mk_rsp(ST_OK, fired[i], slot_handler[fired[i]],
							slot_data[fired[i]], 0, i == fired.size() - 1));
				end
			end
			default: begin
				n = 0;
				while (alarm_order.size() && slot_time[alarm_order[0]] <= q.time_value) begin
					slot_busy[alarm_order[0]] = 0;
					void'(alarm_order.pop_front());
					n++;
				end
				pending_rsp.push_back(mk_rsp(ST_OK, 0, 0, 0, n[PURGE_W-1:0], 1));
			end
		endcase
		return pending_rsp[$].status;
	endfunction

	function automatic void chk_field(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
			err_cnt++;
		end
	endfunction

	// response checker
	always @(posedge clk) begin
		alarm_rsp_t got;
		alarm_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h", $time, got);
				err_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				chk_field("status", want.status, got.status);
				chk_field("out_slot", want.out_slot, got.out_slot);
				chk_field("fired_handler", want.fired_handler, got.fired_handler);
				chk_field("fired_data", want.fired_data, got.fired_data);
				chk_field("purged_count", want.purged_count, got.purged_count);
				chk_field("next_alarm", want.next_alarm, got.next_alarm);
				chk_field("queue_nonempty", want.queue_nonempty, got.queue_nonempty);
				chk_field("last", want.last, got.last);
			end
		end
	end

	// stall watchdog: cycles with no request or response taken
	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		rsp_if.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle);
	end

	task automatic send_alarm_req(alarm_req_t q, bit chk, status_t st);
		status_t got_st;
		while ($urandom_range(0, 99) < src_idle) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= q;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		got_st = predict_alarm(q);
		if (chk && got_st != st) begin
			$display("%0t: directed status, expected %0d, actual %0d", $time, st, got_st);
			err_cnt++;
		end
		@(negedge clk);
	endtask

	function automatic void add_row(cmd_t c, logic [31:0] t, logic [7:0] h, logic [31:0] d,
			logic [3:0] sl, bit chk, status_t st);
		dir_row_t r;
		r.req = '{c, t, h, d, sl};
		r.chk = chk;
		r.st  = st;
		dir_rows.push_back(r);
	endfunction

	// random request, mostly well-formed against the current pool
	function automatic alarm_req_t rand_req(bit fill);
		alarm_req_t q;
		int pick;
		q.time_value    = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 40);
		q.handler       = HANDLER_W'($urandom());
		q.callback_data = $urandom();
		q.slot_id       = SLOT_W'($urandom());
		pick = fill ? 0 : $urandom_range(0, 99);
		if (pick < 45) begin
			q.cmd = CMD_INSERT;
		end else if (pick < 65) begin
			q.cmd = CMD_REMOVE;
			if (alarm_order.size() && $urandom_range(0, 3) != 0)
				q.slot_id = alarm_order[$urandom_range(0, alarm_order.size() - 1)];
		end else if (pick < 88) begin
			q.cmd = CMD_FIRE;
		end else begin
			q.cmd = CMD_SETTM;
			if (alarm_order.size() && $urandom_range(0, 1))
				q.time_value = slot_time[alarm_order[0]] + $urandom_range(0, 12);
		end
		return q;
	endfunction

	initial begin
		int phase_items;
		alarm_req_t q;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		err_cnt = 0;
		src_idle = 33;
		snk_idle = 87;
		foreach (slot_busy[i]) slot_busy[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// corner cases: empty queue, extremes, equal times, purge
		add_row(CMD_FIRE,   32'd0,        8'h00, 32'h0,        4'd0,  1, ST_EMPTY);
		add_row(CMD_REMOVE, 32'd0,        8'h00, 32'h0,        4'd15, 1, ST_NOUSE);
		add_row(CMD_SETTM,  32'hFFFFFFFF, 8'h00, 32'h0,        4'd0,  1, ST_OK);
		add_row(CMD_INSERT, 32'd0,        8'hFF, 32'hFFFFFFFF, 4'd0,  1, ST_OK);
		add_row(CMD_INSERT, 32'hFFFFFFFF, 8'h00, 32'h0,        4'd0,  1, ST_OK);
		add_row(CMD_INSERT, 32'd5,        8'h11, 32'hA5A5A5A5, 4'd0,  0, ST_OK);
		add_row(CMD_INSERT, 32'd5,        8'h22, 32'h5A5A5A5A, 4'd0,  0, ST_OK);
		add_row(CMD_INSERT, 32'd5,        8'h33, 32'h12345678, 4'd0,  0, ST_OK);
		add_row(CMD_INSERT, 32'd3,        8'h44, 32'h0,        4'd0,  0, ST_OK);
		add_row(CMD_FIRE,   32'd0,        8'h00, 32'h0,        4'd0,  0, ST_OK);
		add_row(CMD_REMOVE, 32'd0,        8'h00, 32'h0,        4'd0,  1, ST_NOUSE);
		add_row(CMD_FIRE,   32'd0,        8'h00, 32'h0,        4'd0,  0, ST_OK);
		add_row(CMD_REMOVE, 32'd0,        8'h00, 32'h0,        4'd1,  1, ST_OK);
		add_row(CMD_INSERT, 32'd9,        8'h55, 32'h0,        4'd0,  0, ST_OK);
		add_row(CMD_INSERT, 32'd9,        8'h66, 32'h0,        4'd0,  0, ST_OK);
		add_row(CMD_SETTM,  32'd8,        8'h00, 32'h0,        4'd0,  0, ST_OK);
		add_row(CMD_SETTM,  32'hFFFFFFFF, 8'h00, 32'h0,        4'd0,  0, ST_OK);
		foreach (dir_rows[i])
			send_alarm_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].st);

		// three idle regimes; each opens by filling the pool past full
		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 33 : (ph == 1) ? 87 : 0;
			snk_idle = (ph == 0) ? 87 : (ph == 1) ? 33 : 0;
			phase_items = 0;
			while (phase_items < N_RANDOM / 3) begin
				q = rand_req(phase_items < 18);
				send_alarm_req(q, 0, ST_OK);
				phase_items++;
			end
			// equal-time fan-out of a full pool on the last phase
			if (ph == 2) begin
				for (int i = 0; i < NSLOT; i++) begin
					q = rand_req(1);
					q.time_value = 32'd77;
					send_alarm_req(q, 0, ST_OK);
				end
				q = rand_req(0);
				q.cmd = CMD_FIRE;
				send_alarm_req(q, 0, ST_OK);
			end
		end
		req_if.valid <= 1'b0;

		wait (pending_rsp.size() == 0);
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sorted_alarm_queue_top.f]
rtl/saq_pkg.sv
rtl/saq_if.sv
rtl/saq_front.sv
rtl/saq_back.sv
rtl/sorted_alarm_queue_top.sv
dv/sorted_alarm_queue_top_tb.sv
